// ===== hw/rtl/bsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsp_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;

  // restoring divider width: quotient, dividend and divisor
  localparam int DIV_W = 48;
  // sat helpers work on this wide signed value
  localparam int WIDE_W = 50;
  // bounds arithmetic
  localparam int BND_W = 18;

  localparam logic signed [WIDE_W-1:0] HALF_Q = WIDE_W'(32768);
  localparam logic [DIV_W-1:0] SIZE_NUM = DIV_W'(SCREEN_HEIGHT) << 24;
  localparam logic [DIV_W-1:0] HALF_WIDTH = DIV_W'(SCREEN_WIDTH / 2);
  localparam logic signed [BND_W-1:0] HALF_HEIGHT = BND_W'(SCREEN_HEIGHT / 2);
  localparam logic signed [BND_W-1:0] LAST_COL = BND_W'(SCREEN_WIDTH - 1);
  localparam logic signed [BND_W-1:0] LAST_ROW = BND_W'(SCREEN_HEIGHT - 1);

  typedef enum logic [2:0] {
    REG_CAMERA_X       = 3'd0,
    REG_CAMERA_Y       = 3'd1,
    REG_DIR_X          = 3'd2,
    REG_DIR_Y          = 3'd3,
    REG_PLANE_X        = 3'd4,
    REG_PLANE_Y        = 3'd5,
    REG_VERTICAL_SHIFT = 3'd6,
    REG_SIZE_DIVISOR   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dq;   // dividend shifts out the top, quotient in the bottom
  } div_t;

  typedef struct packed {
    logic [5:0]         index;
    logic               in_front;
    logic signed [31:0] depth;
    logic signed [15:0] column;
    logic [15:0]        size;
    logic signed [15:0] voff;
    logic [14:0]        start_x;
    logic signed [15:0] end_x;
    logic [14:0]        start_y;
    logic signed [15:0] end_y;
  } result_t;

  function automatic div_t div_step(div_t s, logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    div_t r;
    t = {s.rem, s.dq[DIV_W-1]};
    if (t >= {1'b0, d}) begin
      r.rem = DIV_W'(t - {1'b0, d});
      r.dq  = {s.dq[DIV_W-2:0], 1'b1};
    end else begin
      r.rem = t[DIV_W-1:0];
      r.dq  = {s.dq[DIV_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v > WIDE_W'(64'sd2147483647)) r = 32'sh7fffffff;
    else if (v < -WIDE_W'(64'sd2147483648)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [WIDE_W-1:0] v);
    logic signed [15:0] r;
    if (v > WIDE_W'(32767)) r = 16'sh7fff;
    else if (v < -WIDE_W'(32768)) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // signed value from a magnitude quotient and a sign
  function automatic logic signed [WIDE_W-1:0] apply_sign(logic [DIV_W-1:0] q, logic neg);
    logic signed [WIDE_W-1:0] m;
    m = $signed({{(WIDE_W-DIV_W){1'b0}}, q});
    return neg ? -m : m;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/billboard_sprite_projection.sv =====
// Billboard sprite projection for a ray-cast renderer.
// Input channel: in_valid_i / in_stall_o with sprite_index_i, sprite_x_i and
// sprite_y_i (signed Q16.16). A request is taken at a clock edge with valid
// high and stall low. Output channel: out_valid_o / out_stall_i with one
// result per sprite: depth, screen column, size, vertical offset and the
// clamped draw bounds, in request order.
// Camera registers are written through cfg_we_i / cfg_index_i / cfg_data_i;
// the user must write only while no request is in flight; not enforced.
// Throughput: one sprite per cycle while in_stall_o is low; both 48-step
// restoring division stages (two dividers, then three) are fully
// pipelined, one quotient bit per stage.
// When the receiver stalls, the output register holds its result and a skid
// register catches the next one; only once the skid register is full does
// the pipeline freeze and in_stall_o rise. Nothing is lost or repeated.
// Reset clears all valid bits and loads the camera registers with their
// defaults (camera at origin, direction +x, plane y 0.66).
`timescale 1ns / 1ps
`default_nettype none

module billboard_sprite_projection (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [5:0]          sprite_index_i,
  input  wire logic signed [31:0]  sprite_x_i,
  input  wire logic signed [31:0]  sprite_y_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [5:0]               result_index_o,
  output logic                     in_front_o,
  output logic signed [31:0]       depth_o,
  output logic signed [15:0]       screen_column_o,
  output logic [15:0]              sprite_size_o,
  output logic signed [15:0]       vertical_offset_o,
  output logic [14:0]              draw_start_x_o,
  output logic signed [15:0]       draw_end_x_o,
  output logic [14:0]              draw_start_y_o,
  output logic signed [15:0]       draw_end_y_o
);

  localparam int DW = bsp_pkg::DIV_W;
  localparam int WW = bsp_pkg::WIDE_W;
  localparam int BW = bsp_pkg::BND_W;

  // configuration
  logic signed [31:0] cam_x_q, cam_y_q, dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic signed [15:0] vshift_q;
  logic [15:0]        size_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q    <= '0;
      cam_y_q    <= '0;
      dir_x_q    <= 32'sd65536;
      dir_y_q    <= '0;
      plane_x_q  <= '0;
      plane_y_q  <= 32'sd43254;
      vshift_q   <= '0;
      size_div_q <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bsp_pkg::REG_CAMERA_X:       cam_x_q    <= cfg_data_i;
        bsp_pkg::REG_CAMERA_Y:       cam_y_q    <= cfg_data_i;
        bsp_pkg::REG_DIR_X:          dir_x_q    <= cfg_data_i;
        bsp_pkg::REG_DIR_Y:          dir_y_q    <= cfg_data_i;
        bsp_pkg::REG_PLANE_X:        plane_x_q  <= cfg_data_i;
        bsp_pkg::REG_PLANE_Y:        plane_y_q  <= cfg_data_i;
        bsp_pkg::REG_VERTICAL_SHIFT: vshift_q   <= cfg_data_i[15:0];
        bsp_pkg::REG_SIZE_DIVISOR:   size_div_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_q;
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // ---- stage 1: relative position
  logic               v1_q;
  logic [5:0]         idx1_q;
  logic signed [31:0] rx1_q, ry1_q;

  // ---- stage 2: products
  logic               v2_q;
  logic [5:0]         idx2_q;
  logic signed [63:0] p_dyrx_q, p_dxry_q, p_pxry_q, p_pyrx_q, p_pxdy_q, p_dxpy_q;

  // ---- stage 3: inverse camera terms
  logic               v3_q;
  logic [5:0]         idx3_q;
  logic signed [31:0] nx3_q, ny3_q, det3_q;

  // ---- first division (trans_x and depth over det)
  typedef struct packed {
    logic [5:0]  index;
    logic        det_zero;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] dsr;
  } side1_t;

  logic           v1d_q [0:DW];
  side1_t         s1d_q [0:DW];
  bsp_pkg::div_t  dx_q  [0:DW];
  bsp_pkg::div_t  dy_q  [0:DW];

  // ---- stage 5: depth and trans_x
  logic               v5_q;
  logic [5:0]         idx5_q;
  logic               front5_q;
  logic signed [31:0] tx5_q, depth5_q;

  // ---- second division (offset, column, size)
  typedef struct packed {
    logic [5:0]    index;
    logic          front;
    logic [31:0]   depth;
    logic [DW-1:0] dsr_depth;
    logic [DW-1:0] dsr_size;
    logic          neg_v;
    logic          neg_c;
  } side2_t;

  logic           v2d_q [0:DW];
  side2_t         s2d_q [0:DW];
  bsp_pkg::div_t  dv_q  [0:DW];
  bsp_pkg::div_t  dc_q  [0:DW];
  bsp_pkg::div_t  ds_q  [0:DW];

  // ---- stage 7: saturated screen values
  logic               v7_q;
  logic [5:0]         idx7_q;
  logic               front7_q;
  logic signed [31:0] depth7_q;
  logic signed [15:0] voff7_q, col7_q;
  logic [15:0]        size7_q;

  // ---- stage 8: bounds
  logic              v8_q;
  bsp_pkg::result_t  res8_q;

  // output register and skid
  logic              out_valid_q;
  bsp_pkg::result_t  out_q, skid_q;

  // combinational helpers
  logic signed [31:0] rx_c, ry_c, nx_c, ny_c, det_c, tx_c, depth_c;
  logic [31:0]        nx_mag, ny_mag, det_mag;
  logic [15:0]        sd_eff, vs_mag;
  logic signed [33:0] sum_c;
  logic [33:0]        sum_mag;
  logic [DW-1:0]      q_x, q_y, q_v, q_c, q_s;
  logic signed [BW-1:0] half_c, sx_c, ex_c, sy_c, ey_c;

  always_comb begin
    rx_c = bsp_pkg::sat32(WW'(sprite_x_i) + bsp_pkg::HALF_Q - WW'(cam_x_q));
    ry_c = bsp_pkg::sat32(WW'(sprite_y_i) + bsp_pkg::HALF_Q - WW'(cam_y_q));

    // products shifted right 16 with floor: keep the upper bits
    nx_c  = bsp_pkg::sat32(WW'($signed(p_dyrx_q[63:16])) - WW'($signed(p_dxry_q[63:16])));
    ny_c  = bsp_pkg::sat32(WW'($signed(p_pxry_q[63:16])) - WW'($signed(p_pyrx_q[63:16])));
    det_c = bsp_pkg::sat32(WW'($signed(p_pxdy_q[63:16])) - WW'($signed(p_dxpy_q[63:16])));

    nx_mag  = nx3_q[31]  ? 32'(~nx3_q + 32'sd1)  : nx3_q;
    ny_mag  = ny3_q[31]  ? 32'(~ny3_q + 32'sd1)  : ny3_q;
    det_mag = det3_q[31] ? 32'(~det3_q + 32'sd1) : det3_q;

    q_x     = dx_q[DW].dq;
    q_y     = dy_q[DW].dq;
    tx_c    = bsp_pkg::sat32(bsp_pkg::apply_sign(q_x, s1d_q[DW].neg_x));
    depth_c = bsp_pkg::sat32(bsp_pkg::apply_sign(q_y, s1d_q[DW].neg_y));

    sd_eff  = (size_div_q == 16'd0) ? 16'd1 : size_div_q;
    vs_mag  = vshift_q[15] ? 16'(~vshift_q + 16'sd1) : vshift_q;
    sum_c   = 34'(depth5_q) + 34'(tx5_q);
    sum_mag = sum_c[33] ? 34'(~sum_c + 34'sd1) : sum_c;

    q_v = dv_q[DW].dq;
    q_c = dc_q[DW].dq;
    q_s = ds_q[DW].dq;

    half_c = BW'(size7_q[15:1]);
    sx_c   = BW'(col7_q) - half_c;
    ex_c   = BW'(col7_q) + half_c;
    sy_c   = bsp_pkg::HALF_HEIGHT - half_c + BW'(voff7_q);
    ey_c   = bsp_pkg::HALF_HEIGHT + half_c + BW'(voff7_q);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v5_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      for (int k = 0; k <= DW; k++) begin
        v1d_q[k] <= 1'b0;
        v2d_q[k] <= 1'b0;
      end
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v1d_q[0] <= v3_q;
      v5_q     <= v1d_q[DW];
      v2d_q[0] <= v5_q;
      v7_q     <= v2d_q[DW];
      v8_q     <= v7_q;
      for (int k = 1; k <= DW; k++) begin
        v1d_q[k] <= v1d_q[k-1];
        v2d_q[k] <= v2d_q[k-1];
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      idx1_q <= sprite_index_i;
      rx1_q  <= rx_c;
      ry1_q  <= ry_c;

      idx2_q   <= idx1_q;
      p_dyrx_q <= dir_y_q * rx1_q;
      p_dxry_q <= dir_x_q * ry1_q;
      p_pxry_q <= plane_x_q * ry1_q;
      p_pyrx_q <= plane_y_q * rx1_q;
      p_pxdy_q <= plane_x_q * dir_y_q;
      p_dxpy_q <= dir_x_q * plane_y_q;

      idx3_q <= idx2_q;
      nx3_q  <= nx_c;
      ny3_q  <= ny_c;
      det3_q <= det_c;

      s1d_q[0].index    <= idx3_q;
      s1d_q[0].det_zero <= (det3_q == 32'sd0);
      s1d_q[0].neg_x    <= nx3_q[31] ^ det3_q[31];
      s1d_q[0].neg_y    <= ny3_q[31] ^ det3_q[31];
      s1d_q[0].dsr      <= det_mag;
      dx_q[0].rem       <= '0;
      dx_q[0].dq        <= {nx_mag, 16'd0};
      dy_q[0].rem       <= '0;
      dy_q[0].dq        <= {ny_mag, 16'd0};

      for (int k = 1; k <= DW; k++) begin
        s1d_q[k] <= s1d_q[k-1];
        dx_q[k]  <= bsp_pkg::div_step(dx_q[k-1], DW'(s1d_q[k-1].dsr));
        dy_q[k]  <= bsp_pkg::div_step(dy_q[k-1], DW'(s1d_q[k-1].dsr));
      end

      idx5_q   <= s1d_q[DW].index;
      tx5_q    <= tx_c;
      depth5_q <= depth_c;
      front5_q <= !s1d_q[DW].det_zero && !depth_c[31] && (depth_c != 32'sd0);

      s2d_q[0].index     <= idx5_q;
      s2d_q[0].front     <= front5_q;
      s2d_q[0].depth     <= depth5_q;
      s2d_q[0].dsr_depth <= DW'(depth5_q[30:0]);
      s2d_q[0].dsr_size  <= DW'(depth5_q[30:0]) * DW'(sd_eff);
      s2d_q[0].neg_v     <= vshift_q[15];
      s2d_q[0].neg_c     <= sum_c[33];
      dv_q[0].rem        <= '0;
      dv_q[0].dq         <= DW'({vs_mag, 16'd0});
      dc_q[0].rem        <= '0;
      dc_q[0].dq         <= DW'(sum_mag) * bsp_pkg::HALF_WIDTH;
      ds_q[0].rem        <= '0;
      ds_q[0].dq         <= bsp_pkg::SIZE_NUM;

      for (int k = 1; k <= DW; k++) begin
        s2d_q[k] <= s2d_q[k-1];
        dv_q[k]  <= bsp_pkg::div_step(dv_q[k-1], s2d_q[k-1].dsr_depth);
        dc_q[k]  <= bsp_pkg::div_step(dc_q[k-1], s2d_q[k-1].dsr_depth);
        ds_q[k]  <= bsp_pkg::div_step(ds_q[k-1], s2d_q[k-1].dsr_size);
      end

      idx7_q   <= s2d_q[DW].index;
      front7_q <= s2d_q[DW].front;
      depth7_q <= s2d_q[DW].depth;
      voff7_q  <= bsp_pkg::sat16(bsp_pkg::apply_sign(q_v, s2d_q[DW].neg_v));
      col7_q   <= bsp_pkg::sat16(bsp_pkg::apply_sign(q_c, s2d_q[DW].neg_c));
      size7_q  <= (q_s > DW'(65535)) ? 16'hffff : q_s[15:0];

      res8_q.index <= idx7_q;
      if (front7_q) begin
        res8_q.in_front <= 1'b1;
        res8_q.depth    <= depth7_q;
        res8_q.column   <= col7_q;
        res8_q.size     <= size7_q;
        res8_q.voff     <= voff7_q;
        // start_x below 2^15 by range, start_y clamped; end values above -2^15
        res8_q.start_x  <= sx_c[BW-1] ? 15'd0 : sx_c[14:0];
        res8_q.end_x    <= (ex_c > bsp_pkg::LAST_COL) ? 16'(bsp_pkg::LAST_COL) : ex_c[15:0];
        res8_q.start_y  <= sy_c[BW-1] ? 15'd0 :
                           ((sy_c > BW'(32767)) ? 15'h7fff : sy_c[14:0]);
        res8_q.end_y    <= (ey_c > bsp_pkg::LAST_ROW) ? 16'(bsp_pkg::LAST_ROW) : ey_c[15:0];
      end else begin
        res8_q.in_front <= 1'b0;
        res8_q.depth    <= '0;
        res8_q.column   <= '0;
        res8_q.size     <= '0;
        res8_q.voff     <= '0;
        res8_q.start_x  <= '0;
        res8_q.end_x    <= '0;
        res8_q.start_y  <= '0;
        res8_q.end_y    <= '0;
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (skid_v_q) begin
      if (!out_stall_i) skid_v_q <= 1'b0;
    end else if (v8_q) begin
      out_valid_q <= 1'b1;
      if (out_valid_q && out_stall_i) skid_v_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (!out_stall_i) out_q <= skid_q;
    end else if (v8_q) begin
      if (!out_valid_q || !out_stall_i) out_q <= res8_q;
      else skid_q <= res8_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_index_o    = out_q.index;
  assign in_front_o        = out_q.in_front;
  assign depth_o           = out_q.depth;
  assign screen_column_o   = out_q.column;
  assign sprite_size_o     = out_q.size;
  assign vertical_offset_o = out_q.voff;
  assign draw_start_x_o    = out_q.start_x;
  assign draw_end_x_o      = out_q.end_x;
  assign draw_start_y_o    = out_q.start_y;
  assign draw_end_y_o      = out_q.end_y;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_frozen_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> (v8_q == $past(v8_q)) && (v1_q == $past(v1_q)))
    else $error("pipeline moved while skid full");

  a_front_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.in_front) |-> (!out_q.depth[31] && out_q.depth != 32'sd0))
    else $error("in_front with non-positive depth");

  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.in_front) |-> (out_q.size == 16'd0 && out_q.depth == 32'sd0))
    else $error("sprite behind camera with nonzero fields");

endmodule

`default_nettype wire
